### hdl/battery_pack_frame_monitor_macros.svh
// Assertion macros shared by the battery pack frame monitor modules.
// Depends on nothing; included inside module bodies.
`ifndef BATTERY_PACK_FRAME_MONITOR_MACROS_SVH
`define BATTERY_PACK_FRAME_MONITOR_MACROS_SVH
// Implication checked on every edge outside reset.
`define BPFM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BPFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hdl/bpfm_pkg.sv
// Package of the battery pack frame monitor: sizes, register indexes, types.
// Depends on nothing.
package bpfm_pkg;
  localparam int Monitors = 8;
  localparam int CellsPerMon = 16;
  localparam int TempsPerMon = 4;
  localparam int CountWidth = 16;
  localparam int NumCells = Monitors * CellsPerMon;
  localparam int NumTemps = Monitors * TempsPerMon;
  localparam int CellAw = $clog2(NumCells);
  localparam int TempAw = $clog2(NumTemps);
  localparam int MonAw = (Monitors > 1) ? $clog2(Monitors) : 1;
  // First cell of a frame is the four-bit frame number times four.
  localparam int CellOfsW = 6;
  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    REG_CELL_BASE = 3'd0, REG_TEMP_BASE = 3'd1, REG_STAT_BASE = 3'd2,
    REG_OK_MAX = 3'd3, REG_OK_MIN = 3'd4, REG_SIL_LIMIT = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_CELL = 2'd0, CMD_TEMP = 2'd1, CMD_STAT = 2'd2, CMD_TICK = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    PS_NORMAL = 2'd0, PS_SENSOR = 2'd1, PS_LOST = 2'd2
  } pack_state_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CELL, ST_TEMP, ST_MON, ST_DONE
  } back_state_t;

  // One classified request handed from front to back.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [MonAw-1:0] mon;
    logic [3:0]  frame_no;
    logic [63:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [11:0] cell_base;
    logic [11:0] temp_base;
    logic [11:0] stat_base;
    logic [15:0] ok_max;
    logic [15:0] ok_min;
    logic [15:0] sil_limit;
  } cfg_t;
endpackage

### hdl/bpfm_front.sv
// Front end: decodes frame identifiers into requests and queues them.
// Depends on bpfm_pkg.
module bpfm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  bpfm_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [10:0]      in_frame_id,
  input  logic [63:0]      in_payload,
  output logic             q_valid,
  input  logic             q_ready,
  output bpfm_pkg::cmd_t   q_cmd
);
  import bpfm_pkg::*;
  `include "battery_pack_frame_monitor_macros.svh"

  cmd_t q_mem_r [QDepth];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  cmd_t cmd;
  logic keep;
  logic [11:0] id12;
  logic [3:0] mon4;
  logic push, pop;

  always_comb begin
    id12 = {1'b0, in_frame_id};
    cmd = '0;
    cmd.payload = in_payload;
    cmd.frame_no = id12[3:0];
    keep = 1'b0;
    mon4 = 4'd0;
    if (in_op) begin
      cmd.kind = CMD_TICK;
      keep = 1'b1;
    end else if (id12 >= 12'h100 && id12 <= 12'h2FF) begin
      if ((id12 & 12'hF00) == cfg.cell_base) begin
        cmd.kind = CMD_CELL;
        mon4 = id12[7:4];
        keep = 1'b1;
      end else if ((id12 & 12'hFF0) == cfg.temp_base) begin
        cmd.kind = CMD_TEMP;
        mon4 = id12[3:0];
        keep = 1'b1;
      end else if ((id12 & 12'hFF0) == cfg.stat_base) begin
        cmd.kind = CMD_STAT;
        mon4 = id12[3:0];
        keep = 1'b1;
      end
      if (32'(mon4) >= Monitors) keep = 1'b0;
    end
    cmd.mon = mon4[MonAw-1:0];
  end

  assign in_ready = (q_cnt_r != 2'(QDepth));
  assign push = in_valid && in_ready && keep;
  assign q_valid = (q_cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[q_wp_r] <= cmd;
  end

  `BPFM_ASSERT_IMP(a_q_bound, 1'b1, q_cnt_r <= 2'(QDepth))
  `BPFM_ASSERT_NEXT(a_q_full, push && !pop && q_cnt_r == 2'(QDepth - 1), !in_ready)
  `BPFM_ASSERT_IMP(a_tick_kept, in_valid && in_ready && in_op, push)
endmodule

### hdl/bpfm_back.sv
// Back end: stores frame data and walks the stores on each update tick.
// Depends on bpfm_pkg.
module bpfm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  bpfm_pkg::cfg_t cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  bpfm_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_pack_state,
  output logic [23:0]    out_total_voltage,
  output logic [15:0]    out_cell_highest,
  output logic [15:0]    out_cell_lowest,
  output logic [15:0]    out_temp_average,
  output logic [15:0]    out_temp_highest,
  output logic [15:0]    out_temp_lowest,
  output logic           out_volt_high,
  output logic           out_volt_low,
  output logic           out_link_lost
);
  import bpfm_pkg::*;
  `include "battery_pack_frame_monitor_macros.svh"

  localparam int TSumW = 16 + TempAw + 1;

  // Cell store is a memory; valid bits stand in for its reset clear.
  logic [15:0] cell_mem [NumCells];
  logic [NumCells-1:0] cell_vld_r;
  logic [15:0] temp_r [NumTemps];
  logic [15:0] smin_r [Monitors];
  logic [15:0] smax_r [Monitors];
  logic [7:0]  fault_r [Monitors];
  logic [CountWidth-1:0] sil_r [Monitors];
  logic ov_r, uv_r, lost_r;

  back_state_t st_r, st_nxt;
  logic [CellAw:0] idx_r, idx_nxt;
  logic [CellAw-1:0] rd_addr_r;
  logic rd_vld_r, rd_hit_r;
  logic [15:0] rd_data_r;
  logic [24:0] tot_r;
  logic [15:0] hi_r, lo_r;
  logic signed [TSumW-1:0] tsum_r;
  logic signed [16:0] thi_r, tlo_r;

  logic [15:0] cv;
  logic [25:0] tot_add;
  logic signed [16:0] tv;
  logic [CellOfsW-1:0] cell_ofs;
  logic signed [TSumW-1:0] tavg;
  logic [CountWidth-1:0] sil_inc;
  logic [7:0] fb;
  logic take;

  assign take = q_valid && (st_r == ST_IDLE);
  assign q_ready = take && (q_cmd.kind != CMD_TICK || !out_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_ready && q_cmd.kind == CMD_TICK) begin
          st_nxt = ST_CELL;
          idx_nxt = '0;
        end
      end
      ST_CELL: begin
        idx_nxt = idx_r + 1'b1;
        if (rd_vld_r && rd_addr_r == CellAw'(NumCells - 1)) begin
          st_nxt = ST_TEMP;
          idx_nxt = '0;
        end
      end
      ST_TEMP: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (CellAw + 1)'(NumTemps - 1)) begin
          st_nxt = ST_MON;
          idx_nxt = '0;
        end
      end
      ST_MON: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (CellAw + 1)'(Monitors - 1)) st_nxt = ST_DONE;
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // Cell memory: write on cell frames, read one address a cycle while summing.
  always_comb begin
    cell_ofs = CellOfsW'({q_cmd.frame_no, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_cmd.kind == CMD_CELL) begin
      for (int k = 0; k < 4; k++) begin
        if (32'(cell_ofs) + k < CellsPerMon)
          cell_mem[CellAw'(32'(q_cmd.mon) * CellsPerMon + 32'(cell_ofs) + k)]
            <= q_cmd.payload[16*k +: 16];
      end
    end
    rd_data_r <= cell_mem[idx_r[CellAw-1:0]];
    rd_hit_r <= cell_vld_r[idx_r[CellAw-1:0]];
    rd_addr_r <= idx_r[CellAw-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (st_r == ST_CELL) && !(rd_vld_r && rd_addr_r == CellAw'(NumCells - 1));
      if (q_ready && q_cmd.kind == CMD_CELL) begin
        for (int k = 0; k < 4; k++) begin
          if (32'(cell_ofs) + k < CellsPerMon)
            cell_vld_r[CellAw'(32'(q_cmd.mon) * CellsPerMon + 32'(cell_ofs) + k)] <= 1'b1;
        end
      end
    end
  end

  assign cv = rd_hit_r ? rd_data_r : 16'd0;
  assign tot_add = {1'b0, tot_r} + {10'd0, cv};
  assign tv = 17'(signed'(temp_r[idx_r[TempAw-1:0]]));
  assign tavg = TSumW'(tsum_r / NumTemps);
  assign fb = fault_r[idx_r[MonAw-1:0]];
  assign sil_inc = (sil_r[idx_r[MonAw-1:0]] == '1) ? sil_r[idx_r[MonAw-1:0]]
                   : sil_r[idx_r[MonAw-1:0]] + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumTemps; i++) temp_r[i] <= '0;
      for (int i = 0; i < Monitors; i++) begin
        smin_r[i] <= '0;
        smax_r[i] <= '0;
        fault_r[i] <= '0;
        sil_r[i] <= '0;
      end
      ov_r <= 1'b0;
      uv_r <= 1'b0;
      lost_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (q_ready && q_cmd.kind != CMD_TICK) sil_r[q_cmd.mon] <= '0;
      if (q_ready && q_cmd.kind == CMD_TEMP) begin
        for (int k = 0; k < TempsPerMon; k++)
          temp_r[TempAw'(32'(q_cmd.mon) * TempsPerMon + k)] <= q_cmd.payload[16*k +: 16];
      end
      if (q_ready && q_cmd.kind == CMD_STAT) begin
        fault_r[q_cmd.mon] <= q_cmd.payload[7:0];
        smin_r[q_cmd.mon] <= q_cmd.payload[47:32];
        smax_r[q_cmd.mon] <= q_cmd.payload[63:48];
      end
      if (st_r == ST_MON) begin
        if (smax_r[idx_r[MonAw-1:0]] > cfg.ok_max) ov_r <= 1'b1;
        if (smin_r[idx_r[MonAw-1:0]] < cfg.ok_min) uv_r <= 1'b1;
        sil_r[idx_r[MonAw-1:0]] <= sil_inc;
        if (fb != 8'h01 && fb != 8'h02 && fb != 8'h04 && fb != 8'h08)
          lost_r <= (sil_inc > cfg.sil_limit);
      end
      if (st_r == ST_DONE) out_valid <= 1'b1;
    end
  end

  // Accumulators for the walk; cleared as the tick is taken.
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE) begin
      tot_r <= '0;
      hi_r <= 16'd0;
      lo_r <= 16'hFFFF;
      tsum_r <= '0;
      thi_r <= -17'sd10000;
      tlo_r <= 17'sd10000;
    end
    if (rd_vld_r) begin
      tot_r <= tot_add[24] ? 25'h1000000 : tot_add[24:0];
      if (cv > hi_r) hi_r <= cv;
      if (cv < lo_r) lo_r <= cv;
    end
    if (st_r == ST_TEMP) begin
      tsum_r <= tsum_r + TSumW'(tv);
      if (tv > thi_r) thi_r <= tv;
      if (tv < tlo_r) tlo_r <= tv;
    end
    if (st_r == ST_DONE) begin
      out_pack_state <= (ov_r || uv_r) ? PS_SENSOR : (lost_r ? PS_LOST : PS_NORMAL);
      out_total_voltage <= (tot_r > 25'hFFFFFF) ? 24'hFFFFFF : tot_r[23:0];
      out_cell_highest <= hi_r;
      out_cell_lowest <= lo_r;
      out_temp_average <= tavg[15:0];
      out_temp_highest <= thi_r[15:0];
      out_temp_lowest <= tlo_r[15:0];
      out_volt_high <= ov_r;
      out_volt_low <= uv_r;
      out_link_lost <= lost_r;
    end
  end

  `BPFM_ASSERT_NEXT(a_done_valid, st_r == ST_DONE, out_valid)
  `BPFM_ASSERT_IMP(a_walk_no_take, st_r != ST_IDLE, !q_ready)
  `BPFM_ASSERT_IMP(a_flag_state, out_valid && (out_volt_high || out_volt_low), out_pack_state == PS_SENSOR)
endmodule

### hdl/battery_pack_frame_monitor.sv
// Top level of the battery pack frame monitor: configuration registers,
// front decoder with request queue, and back end. Depends on bpfm_pkg.
//
// Input channel in_*: op 0 is a received frame (in_frame_id, in_payload),
// op 1 an update tick. Frames give no result; each tick gives one result
// on the out_* channel. The front decodes a request in the cycle it is
// accepted and places it in a two-entry queue. A frame is stored by the
// back end as it is taken from the queue. A tick walks the cell memory
// one address a cycle (128 cells, read through a registered port), then
// 32 temperatures and 8 monitors, then loads the result into the output
// registers and raises out_valid. The result is held in an output
// register until out_ready; a further tick waits in the queue meanwhile,
// as do frames queued behind it. Reset (rst_n low, synchronous) restores
// register defaults and clears all stores; no clearing pass is needed.
// The user must write configuration through cfg_we, cfg_index and
// cfg_wdata only while the block is idle; the block does not enforce it.
module battery_pack_frame_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [10:0] in_frame_id,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_pack_state,
  output logic [23:0] out_total_voltage,
  output logic [15:0] out_cell_highest,
  output logic [15:0] out_cell_lowest,
  output logic [15:0] out_temp_average,
  output logic [15:0] out_temp_highest,
  output logic [15:0] out_temp_lowest,
  output logic        out_volt_high,
  output logic        out_volt_low,
  output logic        out_link_lost
);
  import bpfm_pkg::*;

  cfg_t cfg_r;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_base <= 12'h100;
      cfg_r.temp_base <= 12'h200;
      cfg_r.stat_base <= 12'h210;
      cfg_r.ok_max <= 16'd42000;
      cfg_r.ok_min <= 16'd30000;
      cfg_r.sil_limit <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_BASE: cfg_r.cell_base <= cfg_wdata[11:0];
        REG_TEMP_BASE: cfg_r.temp_base <= cfg_wdata[11:0];
        REG_STAT_BASE: cfg_r.stat_base <= cfg_wdata[11:0];
        REG_OK_MAX:    cfg_r.ok_max <= cfg_wdata;
        REG_OK_MIN:    cfg_r.ok_min <= cfg_wdata;
        REG_SIL_LIMIT: cfg_r.sil_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpfm_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_valid, .in_ready, .in_op, .in_frame_id,
    .in_payload, .q_valid, .q_ready, .q_cmd
  );

  bpfm_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready,
    .out_pack_state, .out_total_voltage, .out_cell_highest, .out_cell_lowest,
    .out_temp_average, .out_temp_highest, .out_temp_lowest, .out_volt_high,
    .out_volt_low, .out_link_lost
  );
endmodule
